@@ rtl/spa_pkg.sv @@
`timescale 1ns / 1ps

package spa_pkg;

   // store geometry
   localparam int TERMS_PER_POLY = 32;
   localparam int IDX_W          = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
   localparam int CNT_W          = $clog2(TERMS_PER_POLY + 1);

   // field widths
   localparam int KIND_W = 2;
   localparam int COEF_W = 32;
   localparam int SUM_W  = 33;
   localparam int EXP_W  = 16;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

   typedef logic [CNT_W-1:0] cnt_type;

endpackage

@@ rtl/spa_req_if.sv @@
`timescale 1ns / 1ps

interface spa_req_if import spa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic        [KIND_W-1:0] kind;
   logic signed [COEF_W-1:0] coefficient;
   logic        [EXP_W-1:0]  exponent;

   modport source (output valid, kind, coefficient, exponent, input ready);
   modport sink   (input valid, kind, coefficient, exponent, output ready);
endinterface

@@ rtl/spa_rsp_if.sv @@
`timescale 1ns / 1ps

interface spa_rsp_if import spa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] sum_coefficient;
   logic        [EXP_W-1:0] sum_exponent;
   logic                    term_present;
   logic                    last_term;
   logic                    capacity_overflow;

   modport source (output valid, sum_coefficient, sum_exponent, term_present, last_term,
                   capacity_overflow, input ready);
   modport sink   (input valid, sum_coefficient, sum_exponent, term_present, last_term,
                   capacity_overflow, output ready);
endinterface

@@ rtl/sparse_polynomial_adder.sv @@
`timescale 1ns / 1ps
// channel   port    dir  transaction
// -------   ------  ---  ---------------------------------------------------
// request   req_if  in   load a term of A or B, or compute the sum
// response  rsp_if  out  one merged term, last one marked (or one empty item)
//
// a load leaves the block idle; it takes a new request every cycle while idle
// a compute alternates a store read and a merge step (the shared adder and
// exponent compare), then does a final read and a flush of the last term
// a full response register stalls the merge; request ready is low until done
// synchronous active-high reset clears counts, overflow flag and control state
// store contents are not cleared; read data is only used below the fill counts

module sparse_polynomial_adder import spa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   spa_req_if.sink   req_if,
   spa_rsp_if.source rsp_if
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_STEP  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;

   // term stores
   logic [COEF_W-1:0] a_coef_mem [TERMS_PER_POLY];
   logic [EXP_W-1:0]  a_exp_mem  [TERMS_PER_POLY];
   logic [COEF_W-1:0] b_coef_mem [TERMS_PER_POLY];
   logic [EXP_W-1:0]  b_exp_mem  [TERMS_PER_POLY];

   logic [COEF_W-1:0] a_rd_coef_ff, b_rd_coef_ff;
   logic [EXP_W-1:0]  a_rd_exp_ff, b_rd_exp_ff;

   cnt_type a_cnt_ff, a_cnt_in, b_cnt_ff, b_cnt_in;
   cnt_type ia_ff, ia_in, jb_ff, jb_in;
   logic    dropped_ff, dropped_in;

   // pending term, held until we know whether another follows
   logic                    pend_valid_ff, pend_valid_in;
   logic signed [SUM_W-1:0] pend_coef_ff, pend_coef_in;
   logic        [EXP_W-1:0] pend_exp_ff, pend_exp_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic        [EXP_W-1:0] rsp_exp_ff, rsp_exp_in;
   logic                    rsp_present_ff, rsp_present_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic req_fire, out_free, load_a, load_b;
   logic has_a, has_b, take_a, take_b, produce;
   logic signed [SUM_W-1:0] add_a, add_b, sum;

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign load_a   = req_fire && (req_if.kind == KIND_LOAD_A) && (a_cnt_ff < TERMS_PER_POLY);
   assign load_b   = req_fire && (req_if.kind == KIND_LOAD_B) && (b_cnt_ff < TERMS_PER_POLY);

   // store writes and registered head reads
   always_ff @(posedge clock) begin
      if (load_a) begin
         a_coef_mem[a_cnt_ff[IDX_W-1:0]] <= req_if.coefficient;
         a_exp_mem[a_cnt_ff[IDX_W-1:0]]  <= req_if.exponent;
      end
      if (load_b) begin
         b_coef_mem[b_cnt_ff[IDX_W-1:0]] <= req_if.coefficient;
         b_exp_mem[b_cnt_ff[IDX_W-1:0]]  <= req_if.exponent;
      end
      a_rd_coef_ff <= a_coef_mem[ia_ff[IDX_W-1:0]];
      a_rd_exp_ff  <= a_exp_mem[ia_ff[IDX_W-1:0]];
      b_rd_coef_ff <= b_coef_mem[jb_ff[IDX_W-1:0]];
      b_rd_exp_ff  <= b_exp_mem[jb_ff[IDX_W-1:0]];
   end

   // shared compare and adder on the two heads
   always_comb begin
      has_a  = ia_ff < a_cnt_ff;
      has_b  = jb_ff < b_cnt_ff;
      take_a = has_a && (!has_b || (a_rd_exp_ff >= b_rd_exp_ff));
      take_b = has_b && (!has_a || (b_rd_exp_ff >= a_rd_exp_ff));
      add_a  = take_a ? {a_rd_coef_ff[COEF_W-1], a_rd_coef_ff} : '0;
      add_b  = take_b ? {b_rd_coef_ff[COEF_W-1], b_rd_coef_ff} : '0;
      sum    = add_a + add_b;
      // cancelling pair yields nothing
      produce = !(take_a && take_b && (sum == '0));
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      a_cnt_in       = a_cnt_ff;
      b_cnt_in       = b_cnt_ff;
      ia_in          = ia_ff;
      jb_in          = jb_ff;
      dropped_in     = dropped_ff;
      pend_valid_in  = pend_valid_ff;
      pend_coef_in   = pend_coef_ff;
      pend_exp_in    = pend_exp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_coef_in    = rsp_coef_ff;
      rsp_exp_in     = rsp_exp_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_if.kind)
                  KIND_LOAD_A: begin
                     if (load_a) a_cnt_in = a_cnt_ff + cnt_type'(1);
                     else dropped_in = 1'b1;
                  end
                  KIND_LOAD_B: begin
                     if (load_b) b_cnt_in = b_cnt_ff + cnt_type'(1);
                     else dropped_in = 1'b1;
                  end
                  KIND_COMPUTE: begin
                     ia_in    = '0;
                     jb_in    = '0;
                     state_in = ST_READ;
                  end
                  KIND_UNUSED: ;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (!has_a && !has_b) state_in = ST_FLUSH;
            else state_in = ST_STEP;
         end
         ST_STEP: begin
            // a new term pushes the pending one out, if the register is free
            if (!(produce && pend_valid_ff && !out_free)) begin
               if (produce) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in   = 1'b1;
                     rsp_coef_in    = pend_coef_ff;
                     rsp_exp_in     = pend_exp_ff;
                     rsp_present_in = 1'b1;
                     rsp_last_in    = 1'b0;
                     rsp_ovf_in     = dropped_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_coef_in  = sum;
                  pend_exp_in   = take_a ? a_rd_exp_ff : b_rd_exp_ff;
               end
               if (take_a) ia_in = ia_ff + cnt_type'(1);
               if (take_b) jb_in = jb_ff + cnt_type'(1);
               state_in = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_coef_in    = pend_valid_ff ? pend_coef_ff : '0;
               rsp_exp_in     = pend_valid_ff ? pend_exp_ff : '0;
               rsp_present_in = pend_valid_ff;
               rsp_last_in    = 1'b1;
               rsp_ovf_in     = dropped_ff;
               pend_valid_in  = 1'b0;
               a_cnt_in       = '0;
               b_cnt_in       = '0;
               dropped_in     = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         a_cnt_ff      <= '0;
         b_cnt_ff      <= '0;
         ia_ff         <= '0;
         jb_ff         <= '0;
         dropped_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_cnt_ff      <= a_cnt_in;
         b_cnt_ff      <= b_cnt_in;
         ia_ff         <= ia_in;
         jb_ff         <= jb_in;
         dropped_ff    <= dropped_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_coef_ff   <= pend_coef_in;
      pend_exp_ff    <= pend_exp_in;
      rsp_coef_ff    <= rsp_coef_in;
      rsp_exp_ff     <= rsp_exp_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign req_if.ready             = (state_ff == ST_IDLE);
   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.sum_coefficient   = rsp_coef_ff;
   assign rsp_if.sum_exponent      = rsp_exp_ff;
   assign rsp_if.term_present      = rsp_present_ff;
   assign rsp_if.last_term         = rsp_last_ff;
   assign rsp_if.capacity_overflow = rsp_ovf_ff;

   // fill counts never pass the store depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (a_cnt_ff <= TERMS_PER_POLY) && (b_cnt_ff <= TERMS_PER_POLY))
      else $error("store count beyond capacity");

   // no term may be left pending once the merge is back to idle
   pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending term left behind");

   // a flush with a free register always delivers the final transaction
   flush_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("flush did not emit last transaction");

   // an empty transaction is only ever the final one
   empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |-> rsp_last_ff)
      else $error("empty transaction not marked last");

   // merge indices stay within the fill counts
   idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((ia_ff <= a_cnt_ff) && (jb_ff <= b_cnt_ff)))
      else $error("merge index beyond fill count");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import spa_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 2000;
   localparam int ITEMS_PER_MODE = 50;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic signed [COEF_W-1:0] coef;
      logic [EXP_W-1:0]         expo;
   } poly_req_type;

   typedef struct {
      logic signed [SUM_W-1:0] coef;
      logic [EXP_W-1:0]        expo;
      logic                    present;
      logic                    last;
      logic                    ovf;
   } sum_term_type;

   logic clock;
   logic reset;

   spa_req_if req_ch ();
   spa_rsp_if rsp_ch ();

   sparse_polynomial_adder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // stimulus and expected result stores
   poly_req_type req_fifo[$];
   sum_term_type sum_fifo[$];

   // shadow copy of the two term stores
   logic signed [COEF_W-1:0] a_coef [TERMS_PER_POLY];
   logic [EXP_W-1:0]         a_exp  [TERMS_PER_POLY];
   logic signed [COEF_W-1:0] b_coef [TERMS_PER_POLY];
   logic [EXP_W-1:0]         b_exp  [TERMS_PER_POLY];
   int                       a_count;
   int                       b_count;
   logic                     dropped_seen;

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_request;
   bit  hold_started;
   int  hold_left;
   int  stall_cycles;
   int  error_count;
   int  mode_items;

   always #2 clock = ~clock;

   function automatic sum_term_type make_term(input logic signed [SUM_W-1:0] coef,
                                              input logic [EXP_W-1:0] expo,
                                              input logic present);
      sum_term_type t;
      t.coef    = coef;
      t.expo    = expo;
      t.present = present;
      t.last    = 1'b0;
      t.ovf     = dropped_seen;
      return t;
   endfunction

   function automatic logic signed [SUM_W-1:0] widen(input logic signed [COEF_W-1:0] c);
      return {c[COEF_W-1], c};
   endfunction

   // merge predictor: updates the shadow stores and queues the expected terms
   task automatic predict_sum(input poly_req_type r);
      sum_term_type            merged[$];
      int                      i;
      int                      j;
      logic signed [SUM_W-1:0] s;
      i = 0;
      j = 0;
      case (r.kind)
         KIND_LOAD_A: begin
            if (a_count < TERMS_PER_POLY) begin
               a_coef[a_count] = r.coef;
               a_exp[a_count]  = r.expo;
               a_count++;
            end else begin
               dropped_seen = 1'b1;
            end
         end
         KIND_LOAD_B: begin
            if (b_count < TERMS_PER_POLY) begin
               b_coef[b_count] = r.coef;
               b_exp[b_count]  = r.expo;
               b_count++;
            end else begin
               dropped_seen = 1'b1;
            end
         end
         KIND_COMPUTE: begin
            while (i < a_count && j < b_count) begin
               if (a_exp[i] > b_exp[j]) begin
                  merged.push_back(make_term(widen(a_coef[i]), a_exp[i], 1'b1));
                  i++;
               end else if (a_exp[i] < b_exp[j]) begin
                  merged.push_back(make_term(widen(b_coef[j]), b_exp[j], 1'b1));
                  j++;
               end else begin
                  s = widen(a_coef[i]) + widen(b_coef[j]);
                  if (s != 0) merged.push_back(make_term(s, a_exp[i], 1'b1));
                  i++;
                  j++;
               end
            end
            for (; i < a_count; i++) merged.push_back(make_term(widen(a_coef[i]), a_exp[i], 1'b1));
            for (; j < b_count; j++) merged.push_back(make_term(widen(b_coef[j]), b_exp[j], 1'b1));
            // empty sum still gives one marker transaction
            if (merged.size() == 0) merged.push_back(make_term('0, '0, 1'b0));
            merged[merged.size()-1].last = 1'b1;
            foreach (merged[k]) sum_fifo.push_back(merged[k]);
            a_count      = 0;
            b_count      = 0;
            dropped_seen = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   function automatic void check_field(input string name, input logic [SUM_W-1:0] expected,
                                       input logic [SUM_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, expected,
                  actual);
         error_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid       <= 1'b1;
            req_ch.kind        <= req_fifo[0].kind;
            req_ch.coefficient <= req_fifo[0].coef;
            req_ch.exponent    <= req_fifo[0].expo;
            void'(req_fifo.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_started <= 1'b0;
         hold_left    <= 0;
      end else if (hold_request && !hold_started) begin
         hold_started <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses, watchdog
   always @(posedge clock) begin
      poly_req_type r;
      sum_term_type want;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            r.kind = req_ch.kind;
            r.coef = req_ch.coefficient;
            r.expo = req_ch.exponent;
            predict_sum(r);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (sum_fifo.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual coef %0h exp %0h",
                        $realtime, rsp_ch.sum_coefficient, rsp_ch.sum_exponent);
               error_count++;
            end else begin
               want = sum_fifo.pop_front();
               check_field("sum_coefficient", want.coef, rsp_ch.sum_coefficient);
               check_field("sum_exponent", SUM_W'(want.expo), SUM_W'(rsp_ch.sum_exponent));
               check_field("term_present", SUM_W'(want.present), SUM_W'(rsp_ch.term_present));
               check_field("last_term", SUM_W'(want.last), SUM_W'(rsp_ch.last_term));
               check_field("capacity_overflow", SUM_W'(want.ovf),
                           SUM_W'(rsp_ch.capacity_overflow));
            end
         end
         if (moved) begin
            stall_cycles <= 0;
         end else if (req_ch.valid || sum_fifo.size() > 0) begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_req(input logic [KIND_W-1:0] kind, input logic signed [COEF_W-1:0] coef,
                           input logic [EXP_W-1:0] expo);
      poly_req_type r;
      r.kind = kind;
      r.coef = coef;
      r.expo = expo;
      req_fifo.push_back(r);
      if (kind != KIND_UNUSED) mode_items++;
   endtask

   function automatic logic signed [COEF_W-1:0] rand_coef();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return '0;
         3, 4: return $signed(32'($urandom_range(20))) - 10;
         default: return $urandom;
      endcase
   endfunction

   // one well-formed pair of polynomials, interleaved loads with an occasional unused request, then compute
   task automatic push_poly_pair(input bit big);
      logic [EXP_W-1:0]         ea[$];
      logic [EXP_W-1:0]         eb[$];
      logic signed [COEF_W-1:0] ca[$];
      logic signed [COEF_W-1:0] cb[$];
      logic signed [COEF_W-1:0] c;
      int                       n;
      int                       cur;
      int                       step_max;
      int                       pick;
      int                       k;
      int                       ia;
      int                       ib;
      n        = big ? $urandom_range(40, 66) : $urandom_range(0, 9);
      step_max = (big || $urandom_range(1)) ? 3 : 4000;
      cur      = (step_max == 3) ? $urandom_range(400) : $urandom_range(65535);
      if (big) cur = 65535 - $urandom_range(100);
      for (k = 0; k < n && cur >= 0; k++) begin
         pick = $urandom_range(2);
         c    = rand_coef();
         if (pick != 1) begin
            ea.push_back(EXP_W'(cur));
            ca.push_back(c);
         end
         if (pick != 0) begin
            eb.push_back(EXP_W'(cur));
            // shared exponent: sometimes cancel
            cb.push_back((pick == 2 && $urandom_range(2) == 0) ? -c : rand_coef());
         end
         cur -= $urandom_range(1, step_max);
      end
      ia = 0;
      ib = 0;
      while (ia < ea.size() || ib < eb.size()) begin
         if (ib >= eb.size() || (ia < ea.size() && $urandom_range(1))) begin
            push_req(KIND_LOAD_A, ca[ia], ea[ia]);
            ia++;
         end else begin
            push_req(KIND_LOAD_B, cb[ib], eb[ib]);
            ib++;
         end
         if ($urandom_range(29) == 0) push_req(KIND_UNUSED, $urandom, EXP_W'($urandom));
      end
      push_req(KIND_COMPUTE, $urandom, EXP_W'($urandom));
   endtask

   // unordered noise of every kind, then compute
   task automatic push_noise();
      int n;
      int k;
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) push_req(KIND_W'($urandom_range(3)), $urandom, EXP_W'($urandom));
      push_req(KIND_COMPUTE, $urandom, EXP_W'($urandom));
   endtask

   task automatic wait_drained();
      while (req_fifo.size() != 0 || req_ch.valid || sum_fifo.size() != 0) @(negedge clock);
   endtask

   initial begin
      int mode;
      int r;
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_UNUSED;
      req_ch.coefficient = '0;
      req_ch.exponent    = '0;
      rsp_ch.ready       = 1'b0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      hold_request       = 1'b0;
      stall_cycles       = 0;
      error_count        = 0;
      a_count            = 0;
      b_count            = 0;
      dropped_seen       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty sum
      push_req(KIND_COMPUTE, '0, '0);
      // field extremes, largest and smallest exact sums
      push_req(KIND_LOAD_A, 32'sh7FFFFFFF, 16'hFFFF);
      push_req(KIND_LOAD_B, 32'sh7FFFFFFF, 16'hFFFF);
      push_req(KIND_LOAD_A, 32'sh80000000, 16'h0000);
      push_req(KIND_LOAD_B, 32'sh80000000, 16'h0000);
      push_req(KIND_COMPUTE, '1, '1);
      // cancelling terms leave an empty sum
      push_req(KIND_LOAD_A, 5, 10);
      push_req(KIND_LOAD_B, -5, 10);
      push_req(KIND_COMPUTE, '0, '0);
      // zero coefficient passes through, unused kind is ignored
      push_req(KIND_LOAD_A, 0, 3);
      push_req(KIND_UNUSED, 32'sh7FFFFFFF, 16'hFFFF);
      push_req(KIND_COMPUTE, '0, '0);
      // unsorted loads
      push_req(KIND_LOAD_A, 1, 1);
      push_req(KIND_LOAD_A, 2, 9);
      push_req(KIND_LOAD_B, 3, 5);
      push_req(KIND_LOAD_B, 4, 1);
      push_req(KIND_COMPUTE, '0, '0);
      wait_drained();

      // random part across idle modes: none, sender, receiver, both
      for (mode = 0; mode < 4; mode++) begin
         send_idle_pct  = (mode == 1) ? 70 : (mode == 3) ? 34 : 0;
         recv_stall_pct = (mode == 2) ? 70 : (mode == 3) ? 34 : 0;
         mode_items     = 0;
         if (mode == 0) begin
            // long receiver hold-off while a full-size merge is offered
            hold_request = 1'b1;
            push_poly_pair(1'b1);
         end
         while (mode_items < ITEMS_PER_MODE) begin
            r = $urandom_range(19);
            if (r == 0) push_poly_pair(1'b1);
            else if (r < 3) push_noise();
            else push_poly_pair(1'b0);
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (sum_fifo.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
